// File: hdl/okle_pkg.sv
// Package for the ordered key list engine: sizes, request and status codes,
// controller state type and the controller-to-datapath command struct.
// No dependencies.
package okle_pkg;
    localparam int Capacity = 32;
    localparam int IdxW     = $clog2(Capacity);
    localparam int LinkW    = IdxW + 1;
    localparam int CntW     = 6;
    localparam int KeyW     = 32;

    localparam logic [LinkW-1:0] NullLink = LinkW'(Capacity);

    typedef enum logic [2:0] {
        REQ_INSERT   = 3'd0,
        REQ_DEL_KEY  = 3'd1,
        REQ_DEL_HEAD = 3'd2,
        REQ_DEL_TAIL = 3'd3,
        REQ_DUMP     = 3'd4
    } t_req;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS,
        S_SRCH_RD,
        S_SRCH_CHK,
        S_END_RD,
        S_END_CHK,
        S_UNLINK,
        S_DUMP_RD,
        S_DUMP_OUT
    } t_state;

    // Commands from controller to datapath.
    typedef struct packed {
        logic    latch_req;   // capture input key
        logic    do_insert;   // link the captured key at the front
        logic    rd_cur;      // read node at current pointer
        logic    ld_head;     // current pointer <= head
        logic    ld_tail;     // current pointer <= tail
        logic    ld_next;     // current pointer <= next link just read
        logic    do_unlink;   // unlink current node (prev/next just read)
        logic    emit;        // put a result out
        logic    key_sel;     // 1: result key from node read, 0: zero
        t_status st;
        logic    last;
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic full;
        logic empty;
        logic match;
        logic cur_null;
        logic next_null;
    } t_stat;
endpackage

// File: hdl/okle_datapath.sv
// Datapath of the ordered key list engine: node memories, head/tail,
// free stack, walk pointer and result register. Uses okle_pkg.
module okle_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic signed [okle_pkg::KeyW-1:0] i_key,
    input  okle_pkg::t_cmd                  i_cmd,
    output okle_pkg::t_stat                 o_stat,
    output logic                            o_valid,
    output logic signed [okle_pkg::KeyW-1:0] o_out_key,
    output logic [1:0]                      o_status,
    output logic [okle_pkg::CntW-1:0]       o_entry_count,
    output logic                            o_is_last
);
    localparam int IW = okle_pkg::IdxW;
    localparam int LW = okle_pkg::LinkW;

    logic [okle_pkg::KeyW-1:0] r_mkey [okle_pkg::Capacity];
    logic [LW-1:0]             r_mnext [okle_pkg::Capacity];
    logic [LW-1:0]             r_mprev [okle_pkg::Capacity];
    logic [IW-1:0]             r_free [okle_pkg::Capacity];

    logic [LW-1:0] r_head, r_tail, r_cur;
    logic [okle_pkg::CntW-1:0] r_used;
    logic [okle_pkg::KeyW-1:0] r_key, r_rd_key;
    logic [LW-1:0] r_rd_next, r_rd_prev;
    logic [IW-1:0] r_fidx;   // top of free stack, registered
    logic [IW-1:0] r_cidx;   // index of node last read

    logic [IW-1:0] w_top;

    // Free stack is a memory indexed by free count - 1; entry j of a fresh
    // stack holds Capacity-1-j, so node 0 is on top. Until an entry is
    // written the fresh value is used (tracked by a per-entry written bit).
    logic [okle_pkg::Capacity-1:0] r_fwr;
    assign w_top = IW'(okle_pkg::Capacity - 1 - int'(r_used));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwr <= '0;
        end else if (i_cmd.do_unlink && r_used != '0) begin
            r_fwr[IW'(okle_pkg::Capacity - int'(r_used))] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fidx <= r_fwr[w_top] ? r_free[w_top] : IW'(okle_pkg::Capacity - 1) - w_top;
        if (i_cmd.do_unlink && r_used != '0) begin
            r_free[IW'(okle_pkg::Capacity - int'(r_used))] <= r_cidx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_req) begin
            r_key <= i_key;
        end
        if (i_cmd.rd_cur) begin
            r_rd_key  <= r_mkey[r_cur[IW-1:0]];
            r_rd_next <= r_mnext[r_cur[IW-1:0]];
            r_rd_prev <= r_mprev[r_cur[IW-1:0]];
            r_cidx    <= r_cur[IW-1:0];
        end
        if (i_cmd.do_insert) begin
            r_mkey[r_fidx]  <= r_key;
            r_mprev[r_fidx] <= okle_pkg::NullLink;
            r_mnext[r_fidx] <= r_head;
        end
        // Neighbor link updates use the second write port of each link array.
        if (i_cmd.do_insert && !r_head[IW]) begin
            r_mprev[r_head[IW-1:0]] <= {1'b0, r_fidx};
        end
        if (i_cmd.do_unlink) begin
            if (!r_rd_prev[IW]) begin
                r_mnext[r_rd_prev[IW-1:0]] <= r_rd_next;
            end
            if (!r_rd_next[IW]) begin
                r_mprev[r_rd_next[IW-1:0]] <= r_rd_prev;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= okle_pkg::NullLink;
            r_tail  <= okle_pkg::NullLink;
            r_used  <= '0;
            r_cur   <= okle_pkg::NullLink;
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.emit;
            if (i_cmd.do_insert) begin
                r_head <= {1'b0, r_fidx};
                if (r_tail[IW]) begin
                    r_tail <= {1'b0, r_fidx};
                end
                r_used <= r_used + 1'b1;
            end
            if (i_cmd.do_unlink) begin
                if (r_rd_prev[IW]) begin
                    r_head <= r_rd_next;
                end
                if (r_rd_next[IW]) begin
                    r_tail <= r_rd_prev;
                end
                if (r_used != '0) begin
                    r_used <= r_used - 1'b1;
                end
            end
            if (i_cmd.ld_head) begin
                r_cur <= r_head;
            end else if (i_cmd.ld_tail) begin
                r_cur <= r_tail;
            end else if (i_cmd.ld_next) begin
                r_cur <= r_rd_next;
            end
        end
    end

    // Entry count is the count after this request; unlink and emit share
    // the cycle, so the count is adjusted here.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_out_key     <= i_cmd.key_sel ? r_rd_key : '0;
            o_status      <= i_cmd.st;
            o_is_last     <= i_cmd.last;
            o_entry_count <= r_used
                - ((i_cmd.do_unlink && r_used != '0) ? 6'd1 : 6'd0)
                + (i_cmd.do_insert ? 6'd1 : 6'd0);
        end
    end

    assign o_stat.full      = (int'(r_used) >= okle_pkg::Capacity);
    assign o_stat.empty     = r_head[IW];
    assign o_stat.match     = (r_rd_key == r_key);
    assign o_stat.cur_null  = r_cur[IW];
    assign o_stat.next_null = r_rd_next[IW];
endmodule

// File: hdl/okle_ctrl.sv
// Controller of the ordered key list engine: request decode and list walk
// sequencing. Uses okle_pkg.
module okle_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [2:0]      i_req_type,
    input  okle_pkg::t_stat i_stat,
    output logic            o_busy,
    output okle_pkg::t_cmd  o_cmd
);
    okle_pkg::t_state r_state, n_state;
    logic [okle_pkg::CntW-1:0] r_steps, n_steps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= okle_pkg::S_IDLE;
            r_steps <= '0;
        end else begin
            r_state <= n_state;
            r_steps <= n_steps;
        end
    end

    always_comb begin
        n_state = r_state;
        n_steps = r_steps;
        o_cmd   = '0;
        o_cmd.st = okle_pkg::ST_OK;
        o_cmd.last = 1'b1;
        o_busy  = (r_state != okle_pkg::S_IDLE);
        case (r_state)
            okle_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd.latch_req = 1'b1;
                    n_steps = '0;
                    case (i_req_type)
                        okle_pkg::REQ_INSERT: begin
                            if (i_stat.full) begin
                                o_cmd.emit = 1'b1;
                                o_cmd.st = okle_pkg::ST_FULL;
                            end else begin
                                n_state = okle_pkg::S_INS;
                            end
                        end
                        okle_pkg::REQ_DEL_KEY, okle_pkg::REQ_DUMP: begin
                            if (i_stat.empty) begin
                                o_cmd.emit = 1'b1;
                                o_cmd.st = okle_pkg::ST_EMPTY;
                            end else begin
                                o_cmd.ld_head = 1'b1;
                                n_state = (i_req_type == okle_pkg::REQ_DUMP)
                                        ? okle_pkg::S_DUMP_RD : okle_pkg::S_SRCH_RD;
                            end
                        end
                        okle_pkg::REQ_DEL_HEAD, okle_pkg::REQ_DEL_TAIL: begin
                            if (i_stat.empty) begin
                                o_cmd.emit = 1'b1;
                                o_cmd.st = okle_pkg::ST_EMPTY;
                            end else begin
                                o_cmd.ld_head = (i_req_type == okle_pkg::REQ_DEL_HEAD);
                                o_cmd.ld_tail = (i_req_type == okle_pkg::REQ_DEL_TAIL);
                                n_state = okle_pkg::S_END_RD;
                            end
                        end
                        default: begin
                            o_cmd.emit = 1'b1;
                        end
                    endcase
                end
            end
            okle_pkg::S_INS: begin
                // Free stack top was registered in the previous cycle.
                o_cmd.do_insert = 1'b1;
                o_cmd.emit = 1'b1;
                n_state = okle_pkg::S_IDLE;
            end
            okle_pkg::S_SRCH_RD: begin
                if (i_stat.cur_null || int'(r_steps) >= okle_pkg::Capacity) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.st = okle_pkg::ST_NOTFOUND;
                    n_state = okle_pkg::S_IDLE;
                end else begin
                    o_cmd.rd_cur = 1'b1;
                    n_steps = r_steps + 1'b1;
                    n_state = okle_pkg::S_SRCH_CHK;
                end
            end
            okle_pkg::S_SRCH_CHK: begin
                if (i_stat.match) begin
                    o_cmd.do_unlink = 1'b1;
                    o_cmd.emit = 1'b1;
                    o_cmd.key_sel = 1'b1;
                    n_state = okle_pkg::S_IDLE;
                end else begin
                    o_cmd.ld_next = 1'b1;
                    n_state = okle_pkg::S_SRCH_RD;
                end
            end
            okle_pkg::S_END_RD: begin
                o_cmd.rd_cur = 1'b1;
                n_state = okle_pkg::S_UNLINK;
            end
            okle_pkg::S_UNLINK: begin
                o_cmd.do_unlink = 1'b1;
                o_cmd.emit = 1'b1;
                o_cmd.key_sel = 1'b1;
                n_state = okle_pkg::S_IDLE;
            end
            okle_pkg::S_DUMP_RD: begin
                o_cmd.rd_cur = 1'b1;
                n_steps = r_steps + 1'b1;
                n_state = okle_pkg::S_DUMP_OUT;
            end
            okle_pkg::S_DUMP_OUT: begin
                o_cmd.emit = 1'b1;
                o_cmd.key_sel = 1'b1;
                o_cmd.ld_next = 1'b1;
                o_cmd.last = i_stat.next_null || int'(r_steps) >= okle_pkg::Capacity;
                n_state = o_cmd.last ? okle_pkg::S_IDLE : okle_pkg::S_DUMP_RD;
            end
            default: begin
                n_state = okle_pkg::S_IDLE;
            end
        endcase
    end

    a_emit_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.do_unlink |-> o_cmd.emit) else $error("unlink without result");
    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && o_cmd.last) |=> r_state == okle_pkg::S_IDLE)
        else $error("walk continued after last result");
    a_no_insert_unlink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.do_insert && o_cmd.do_unlink)) else $error("insert and unlink together");
endmodule

// File: hdl/ordered_key_list_engine.sv
// Ordered key list engine top level: a doubly linked list of signed keys.
// Rejected requests answer from idle; insert goes through S_INS; front/back delete
// reads then unlinks the end node; delete by key and dump walk at most 32 entries.
// One request at a time; busy is high until the last result is shown.
// Synchronous active-low reset empties the list; results cannot be stalled.
// Depends on okle_pkg, okle_ctrl and okle_datapath.
module ordered_key_list_engine (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [2:0]                       i_req_type,
    input  logic signed [okle_pkg::KeyW-1:0] i_key,
    output logic                             o_strobe,
    output logic signed [okle_pkg::KeyW-1:0] o_out_key,
    output logic [1:0]                       o_status,
    output logic [okle_pkg::CntW-1:0]        o_entry_count,
    output logic                             o_is_last
);
    okle_pkg::t_cmd  w_cmd;
    okle_pkg::t_stat w_stat;

    okle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req_type),
        .i_stat     (w_stat),
        .o_busy     (busy),
        .o_cmd      (w_cmd)
    );

    okle_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_key         (i_key),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_valid       (o_strobe),
        .o_out_key     (o_out_key),
        .o_status      (o_status),
        .o_entry_count (o_entry_count),
        .o_is_last     (o_is_last)
    );
endmodule
